FILE: design/qte_pkg.sv
`default_nettype none
package qte_pkg;

  // datapath widths
  localparam int PW = 34;   // numerators, denominators, asin argument (2^30 = one)
  localparam int DW = 38;   // CORDIC x/y with gain headroom
  localparam int AW = 34;   // angle accumulator, 2^30 = one
  localparam int RW = 31;   // square root result
  localparam int NW = 61;   // square root radicand / remainder
  localparam int SIDE_W = 5 * PW + 1;
  localparam int TABLE_LEN = 24;

  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [PW-1:0] ONE_Q30 = 34'sd1073741824;
  localparam logic [NW-1:0] FULL_Q60 = 61'h1000000000000000;
  localparam logic signed [15:0] PI_Q13 = 16'sd25736;
  localparam logic signed [15:0] HALF_PI_Q13 = 16'sd12868;

  typedef struct packed {
    logic signed [DW-1:0] x;
    logic signed [DW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 zero;
  } vec_t;

  typedef struct packed {
    logic sat;
    logic neg;
  } pitch_side_t;

  // atan(2^-i), 2^30 = one
  function automatic logic [31:0] atan_q30(int i);
    logic [31:0] r;
    case (i)
      0: r = 32'h3243F6A8;   1: r = 32'h1DAC6705;   2: r = 32'h0FADBAFC;
      3: r = 32'h07F56EA6;   4: r = 32'h03FEAB76;   5: r = 32'h01FFD55B;
      6: r = 32'h00FFFAAA;   7: r = 32'h007FFF55;   8: r = 32'h003FFFEA;
      9: r = 32'h001FFFFD;  10: r = 32'h000FFFFF;  11: r = 32'h0007FFFF;
      12: r = 32'h0003FFFF; 13: r = 32'h0001FFFF;  14: r = 32'h0000FFFF;
      15: r = 32'h00007FFF; 16: r = 32'h00003FFF;  17: r = 32'h00001FFF;
      18: r = 32'h00000FFF; 19: r = 32'h000007FF;  20: r = 32'h000003FF;
      21: r = 32'h000001FF; 22: r = 32'h000000FF;  23: r = 32'h0000007F;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

  // quarter-turn prerotation for a negative abscissa
  function automatic vec_t prerot(logic signed [DW-1:0] y, logic signed [DW-1:0] x);
    vec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x[DW-1]) begin
      if (!y[DW-1]) begin
        v.x = y;
        v.y = -x;
        v.acc = HALF_PI_Q30;
      end else begin
        v.x = -y;
        v.y = x;
        v.acc = -HALF_PI_Q30;
      end
    end else begin
      v.x = x;
      v.y = y;
      v.acc = '0;
    end
    return v;
  endfunction

  // accumulator to Q3.13, round half up, clamp to +-lim
  function automatic logic signed [15:0] to_q13(logic signed [AW-1:0] a,
                                                logic signed [15:0] lim);
    logic signed [AW-1:0] t;
    logic signed [AW-1:0] l;
    logic signed [15:0] r;
    t = (a + 34'sd65536) >>> 17;
    l = AW'(lim);
    if (t > l) r = lim;
    else if (t < -l) r = -lim;
    else r = t[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: design/qte_in_if.sv
`default_nettype none
interface qte_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface
`default_nettype wire

FILE: design/qte_out_if.sv
`default_nettype none
interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [14:0] pitch_angle;
  logic signed [15:0] yaw_angle;
  logic               pitch_saturated;

  modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                  input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, pitch_saturated,
                output ready);
endinterface
`default_nettype wire

FILE: design/qte_sqrt_cell.sv
`default_nettype none
// one result bit of a restoring square root
module qte_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        en_i,
  input  wire logic                        valid_i,
  input  wire logic [qte_pkg::NW-1:0]      rem_i,
  input  wire logic [qte_pkg::RW-1:0]      root_i,
  input  wire logic [qte_pkg::SIDE_W-1:0]  side_i,
  output logic                             valid_o,
  output logic [qte_pkg::NW-1:0]           rem_o,
  output logic [qte_pkg::RW-1:0]           root_o,
  output logic [qte_pkg::SIDE_W-1:0]       side_o
);
  localparam int TW = qte_pkg::NW + 1;

  logic [TW-1:0] trial;
  logic          fits;

  // (root + 2^BIT)^2 - root^2
  assign trial = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign fits  = {1'b0, rem_i} >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= fits ? rem_i - trial[qte_pkg::NW-1:0] : rem_i;
      root_o <= fits ? (root_i | (qte_pkg::RW'(1) << BIT)) : root_i;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

FILE: design/qte_cordic_cell.sv
`default_nettype none
// one vectoring micro-rotation, three lanes side by side
module qte_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 en_i,
  input  wire logic                 valid_i,
  input  wire qte_pkg::vec_t [2:0]  vec_i,
  input  wire qte_pkg::pitch_side_t side_i,
  output logic                      valid_o,
  output qte_pkg::vec_t [2:0]       vec_o,
  output qte_pkg::pitch_side_t      side_o
);
  localparam logic [31:0] ATAN = qte_pkg::atan_q30(IDX);
  localparam logic signed [qte_pkg::AW-1:0] ATAN_S = qte_pkg::AW'(ATAN);

  qte_pkg::vec_t [2:0] nxt;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      nxt[l].zero = vec_i[l].zero;
      if (!vec_i[l].y[qte_pkg::DW-1]) begin
        nxt[l].x   = vec_i[l].x + (vec_i[l].y >>> IDX);
        nxt[l].y   = vec_i[l].y - (vec_i[l].x >>> IDX);
        nxt[l].acc = vec_i[l].acc + ATAN_S;
      end else begin
        nxt[l].x   = vec_i[l].x - (vec_i[l].y >>> IDX);
        nxt[l].y   = vec_i[l].y + (vec_i[l].x >>> IDX);
        nxt[l].acc = vec_i[l].acc - ATAN_S;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o  <= nxt;
      side_o <= side_i;
    end
  end
endmodule
`default_nettype wire

FILE: design/quaternion_to_euler_angles_unit.sv
// Quaternion to roll / pitch / yaw, fully pipelined.
// in_i (sink): one word carries quat_w, quat_x, quat_y, quat_z in signed Q1.15.
// out_o (source): one word carries roll_angle, yaw_angle (Q3.13, +-pi),
//   pitch_angle (Q2.13, +-pi/2) and pitch_saturated.
// Throughput: one word per cycle while out_o is not stalled; every stage of the pipe is a register.
// Stages from the accepting edge to out valid:
//   quaternion register, products, sums, asin range check, s^2, a 31-cell
//   bit-per-cell square root chain, quarter-turn prerotation, a chain of
//   min(CORDIC_STAGES, TABLE_LEN) micro-rotation cells (three lanes each), output register.
// Stall: the whole pipe advances only when the output register is empty or
//   being taken, so in_i.ready drops in the cycle out_o waits; words in flight
//   hold their place and nothing is lost. A new word is accepted in the same
//   cycle a waiting result is taken.
// Reset: clears every valid bit; the pipe comes up empty and ready.
`default_nettype none
module quaternion_to_euler_angles_unit #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qte_in_if.sink     in_i,
  qte_out_if.source  out_o
);
  localparam int N = (CORDIC_STAGES > qte_pkg::TABLE_LEN) ? qte_pkg::TABLE_LEN
                                                          : CORDIC_STAGES;
  localparam int PW = qte_pkg::PW;
  localparam int DW = qte_pkg::DW;
  localparam int RW = qte_pkg::RW;
  localparam int SQ = RW;  // one cell per root bit

  logic adv;
  logic out_v_q;

  // the whole pipe moves as one
  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  // stage 1: quaternion register
  logic v1_q;
  logic signed [15:0] w_q, x_q, y_q, z_q;

  // stage 2: products
  logic v2_q;
  logic signed [31:0] wx_q, zy_q, zw_q, xy_q, xx_q, yy_q, ww_q, yw_q, zx_q;

  // stage 3: numerators, denominators, asin argument
  logic v3_q;
  logic signed [PW-1:0] rn_q, rd_q, yn_q, yd_q, s_q;

  // stage 4: range check, |s|
  logic v4_q;
  logic signed [PW-1:0] rn4_q, rd4_q, yn4_q, yd4_q, s4_q;
  logic sat4_q;
  logic [RW-1:0] a4_q;
  logic sat_d;

  // stage 5: s^2
  logic v5_q;
  logic [2*RW-1:0] ss_q;
  logic [qte_pkg::SIDE_W-1:0] side5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign sat_d = (s_q > qte_pkg::ONE_Q30) || (s_q < -qte_pkg::ONE_Q30);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      w_q <= in_i.quat_w;
      x_q <= in_i.quat_x;
      y_q <= in_i.quat_y;
      z_q <= in_i.quat_z;

      wx_q <= w_q * x_q;
      zy_q <= z_q * y_q;
      zw_q <= z_q * w_q;
      xy_q <= x_q * y_q;
      xx_q <= x_q * x_q;
      yy_q <= y_q * y_q;
      ww_q <= w_q * w_q;
      yw_q <= y_q * w_q;
      zx_q <= z_q * x_q;

      rn_q <= (PW'(zy_q) + PW'(wx_q)) <<< 1;
      rd_q <= qte_pkg::ONE_Q30 - ((PW'(xx_q) + PW'(yy_q)) <<< 1);
      yn_q <= (PW'(zw_q) + PW'(xy_q)) <<< 1;
      yd_q <= ((PW'(ww_q) + PW'(xx_q)) <<< 1) - qte_pkg::ONE_Q30;
      s_q  <= (PW'(yw_q) - PW'(zx_q)) <<< 1;

      rn4_q  <= rn_q;
      rd4_q  <= rd_q;
      yn4_q  <= yn_q;
      yd4_q  <= yd_q;
      s4_q   <= s_q;
      sat4_q <= sat_d;
      // clamped argument is left at zero; its pitch is replaced at the end
      a4_q   <= sat_d ? '0 : (s_q[PW-1] ? RW'(-s_q) : RW'(s_q));

      ss_q    <= a4_q * a4_q;
      side5_q <= {rn4_q, rd4_q, yn4_q, yd4_q, s4_q, sat4_q};
    end
  end

  // square root chain: sqrt(1 - s^2)
  logic                       sq_v    [0:SQ];
  logic [qte_pkg::NW-1:0]     sq_rem  [0:SQ];
  logic [RW-1:0]              sq_root [0:SQ];
  logic [qte_pkg::SIDE_W-1:0] sq_side [0:SQ];

  assign sq_v[0]    = v5_q;
  assign sq_rem[0]  = qte_pkg::FULL_Q60 - qte_pkg::NW'(ss_q);
  assign sq_root[0] = '0;
  assign sq_side[0] = side5_q;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    qte_sqrt_cell #(.BIT(SQ - 1 - k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (sq_v[k]),
      .rem_i   (sq_rem[k]),
      .root_i  (sq_root[k]),
      .side_i  (sq_side[k]),
      .valid_o (sq_v[k+1]),
      .rem_o   (sq_rem[k+1]),
      .root_o  (sq_root[k+1]),
      .side_o  (sq_side[k+1])
    );
  end

  // prerotation stage
  logic signed [PW-1:0] rn_s, rd_s, yn_s, yd_s, s_s;
  logic                 sat_s;
  logic                 pre_v_q;
  qte_pkg::vec_t [2:0]  pre_q;
  qte_pkg::pitch_side_t pre_side_q;

  assign {rn_s, rd_s, yn_s, yd_s, s_s, sat_s} = sq_side[SQ];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q <= 1'b0;
    end else if (adv) begin
      pre_v_q <= sq_v[SQ];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      // lane 0 roll, lane 1 pitch, lane 2 yaw
      pre_q[0] <= qte_pkg::prerot(DW'(rn_s), DW'(rd_s));
      pre_q[1] <= qte_pkg::prerot(DW'(s_s), DW'({1'b0, sq_root[SQ]}));
      pre_q[2] <= qte_pkg::prerot(DW'(yn_s), DW'(yd_s));
      pre_side_q.sat <= sat_s;
      pre_side_q.neg <= s_s[PW-1];
    end
  end

  // CORDIC chain
  logic                 co_v    [0:N];
  qte_pkg::vec_t [2:0]  co_vec  [0:N];
  qte_pkg::pitch_side_t co_side [0:N];

  assign co_v[0]    = pre_v_q;
  assign co_vec[0]  = pre_q;
  assign co_side[0] = pre_side_q;

  for (genvar i = 0; i < N; i++) begin : g_cordic
    qte_cordic_cell #(.IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (co_v[i]),
      .vec_i   (co_vec[i]),
      .side_i  (co_side[i]),
      .valid_o (co_v[i+1]),
      .vec_o   (co_vec[i+1]),
      .side_o  (co_side[i+1])
    );
  end

  // output register
  logic signed [15:0] roll_d, yaw_d, pitch_d;
  logic signed [15:0] roll_q, yaw_q;
  logic signed [14:0] pitch_q;
  logic               sat_q;

  always_comb begin
    // both operands zero reads as angle zero
    roll_d = co_vec[N][0].zero ? '0 : qte_pkg::to_q13(co_vec[N][0].acc, qte_pkg::PI_Q13);
    yaw_d  = co_vec[N][2].zero ? '0 : qte_pkg::to_q13(co_vec[N][2].acc, qte_pkg::PI_Q13);
    if (co_side[N].sat) begin
      pitch_d = co_side[N].neg ? -qte_pkg::HALF_PI_Q13 : qte_pkg::HALF_PI_Q13;
    end else if (co_vec[N][1].zero) begin
      pitch_d = '0;
    end else begin
      pitch_d = qte_pkg::to_q13(co_vec[N][1].acc, qte_pkg::HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= co_v[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      roll_q  <= roll_d;
      yaw_q   <= yaw_d;
      pitch_q <= pitch_d[14:0];
      sat_q   <= co_side[N].sat;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.roll_angle      = roll_q;
  assign out_o.pitch_angle     = pitch_q;
  assign out_o.yaw_angle       = yaw_q;
  assign out_o.pitch_saturated = sat_q;
endmodule
`default_nettype wire

FILE: design/qte_checker.sv
`default_nettype none
module qte_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic signed [15:0] roll_i,
  input wire logic signed [14:0] pitch_i,
  input wire logic               sat_i
);
  // a waiting word stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("out valid dropped while stalled");

  // an empty or taken output always leaves the input open
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input blocked without a stall");

  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && sat_i |-> pitch_i == 15'sd12868 || pitch_i == -15'sd12868)
    else $error("saturated pitch not at +-pi/2");

  a_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> roll_i <= 16'sd25736 && roll_i >= -16'sd25736)
    else $error("roll out of range");
endmodule

bind quaternion_to_euler_angles_unit qte_checker u_qte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .roll_i      (out_o.roll_angle),
  .pitch_i     (out_o.pitch_angle),
  .sat_i       (out_o.pitch_saturated)
);
`default_nettype wire
